// ===== hdl/fcpu_pkg.sv =====
// Shared types, constants and helper functions for the fly camera pose update block
package fcpu_pkg;

   localparam int CordicSteps = 16;
   localparam int StepIdxW    = 4;
   localparam int CordicW     = 36;
   localparam logic signed [CordicW-1:0] CordicStart = 36'sd163008219;
   localparam logic signed [32:0] PitchLimit = 33'sd1073197483;
   localparam logic [23:0] SensReset  = 24'd546852;
   localparam logic signed [31:0] PosZReset = 32'sd196608;
   localparam logic signed [15:0] OneQ14    = 16'sd16384;
   localparam logic [31:0] YawReset   = 32'hC000_0000;

   typedef enum logic [2:0] {
      OP_CURSOR   = 3'd0,
      OP_UP       = 3'd1,
      OP_DOWN     = 3'd2,
      OP_FORWARD  = 3'd3,
      OP_BACKWARD = 3'd4,
      OP_LEFT     = 3'd5,
      OP_RIGHT    = 3'd6,
      OP_NONE     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      CSR_SPEED = 2'd0,
      CSR_SENS  = 2'd1
   } csr_idx_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture transaction and apply turn update
      logic cor_start; // seed cordic from angle select
      logic cor_sel;   // 0 yaw, 1 pitch
      logic cor_step;  // one cordic iteration
      logic cor_done;  // round result into latch
      logic dir_mul;   // build direction from latched sin/cos
      logic move_mul;  // form move products
      logic move_add;  // add products into position
   } cmd_type;

   typedef struct packed {
      logic       last_step;
      logic [2:0] op;
   } status_type;

   function automatic logic signed [CordicW-1:0] atan_lut(input logic [StepIdxW-1:0] i);
      logic signed [CordicW-1:0] r;
      case (i)
         4'd0:  r = 36'sd536870912;
         4'd1:  r = 36'sd316933406;
         4'd2:  r = 36'sd167458907;
         4'd3:  r = 36'sd85004756;
         4'd4:  r = 36'sd42667331;
         4'd5:  r = 36'sd21354465;
         4'd6:  r = 36'sd10679838;
         4'd7:  r = 36'sd5340245;
         4'd8:  r = 36'sd2670163;
         4'd9:  r = 36'sd1335087;
         4'd10: r = 36'sd667544;
         4'd11: r = 36'sd333772;
         4'd12: r = 36'sd166886;
         4'd13: r = 36'sd83443;
         4'd14: r = 36'sd41721;
         default: r = 36'sd20861;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_unit(input logic signed [CordicW-1:0] v);
      logic signed [15:0] r;
      if (v > 36'sd16384) r = OneQ14;
      else if (v < -36'sd16384) r = -OneQ14;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== hdl/fcpu_datapath.sv =====
// Datapath: pose state, turn update, shared CORDIC and move arithmetic
module fcpu_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fcpu_pkg::cmd_type       cmd,
   output fcpu_pkg::status_type    status,
   input  logic [2:0]              req_op,
   input  logic signed [15:0]      req_cursor_x,
   input  logic signed [15:0]      req_cursor_y,
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [23:0]             csr_data,
   output logic signed [31:0]      pos_x,
   output logic signed [31:0]      pos_y,
   output logic signed [31:0]      pos_z,
   output logic signed [15:0]      dir_x,
   output logic signed [15:0]      dir_y,
   output logic signed [15:0]      dir_z
);
   import fcpu_pkg::*;

   logic [23:0] speed_ff, speed_in, sens_ff, sens_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [15:0] dir_ff [3];
   logic signed [15:0] dir_in [3];
   logic [31:0] yaw_ff, yaw_in;
   logic signed [31:0] pitch_ff, pitch_in;
   logic signed [15:0] lcx_ff, lcx_in, lcy_ff, lcy_in;
   logic first_ff, first_in;
   logic [2:0] op_ff, op_in;
   logic signed [CordicW-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic neg_ff, neg_in;
   logic [StepIdxW-1:0] step_ff, step_in;
   logic signed [15:0] sy_ff, sy_in, cyw_ff, cyw_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [40:0] prod_ff [3];
   logic signed [40:0] prod_in [3];

   logic signed [16:0] dx, dy;
   logic signed [15:0] bx, by;
   logic signed [41:0] tdx, tdy;
   logic signed [42:0] pch;
   logic [31:0] ang, angf;
   logic signed [CordicW-1:0] sx, sy2, rx, ry;
   logic signed [15:0] csn, ccs;
   logic signed [24:0] sp;
   logic signed [16:0] vec [3];
   logic signed [31:0] mp0, mp2;

   always_comb begin
      bx = first_ff ? req_cursor_x : lcx_ff;
      by = first_ff ? req_cursor_y : lcy_ff;
      dx = 17'(req_cursor_x) - 17'(bx);
      dy = 17'(req_cursor_y) - 17'(by);
      tdx = $signed({1'b0, sens_ff}) * dx;
      tdy = $signed({1'b0, sens_ff}) * dy;
      pch = 43'(pitch_ff) - 43'(tdy);
      ang = cmd.cor_sel ? pitch_ff : yaw_ff;
      angf = (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) ? ang + 32'h8000_0000 : ang;
      sx = cx_ff >>> step_ff;
      sy2 = cy_ff >>> step_ff;
      rx = (cx_ff + 36'sd8192) >>> 14;
      ry = (cy_ff + 36'sd8192) >>> 14;
      ccs = clamp_unit(neg_ff ? -rx : rx);
      csn = clamp_unit(neg_ff ? -ry : ry);
      sp = (op_ff == OP_DOWN || op_ff == OP_BACKWARD || op_ff == OP_RIGHT)
           ? -$signed({1'b0, speed_ff}) : $signed({1'b0, speed_ff});
      vec[0] = 17'sd0; vec[1] = 17'sd0; vec[2] = 17'sd0;
      case (op_ff)
         OP_UP, OP_DOWN: vec[1] = 17'(OneQ14);
         OP_FORWARD, OP_BACKWARD: begin
            vec[0] = 17'(dir_ff[0]); vec[1] = 17'(dir_ff[1]); vec[2] = 17'(dir_ff[2]);
         end
         OP_LEFT, OP_RIGHT: begin
            vec[0] = 17'(sy_ff); vec[2] = -17'(cyw_ff);
         end
         default: ;
      endcase
      mp0 = 32'(cyw_ff) * 32'(cp_ff);
      mp2 = 32'(sy_ff) * 32'(cp_ff);

      speed_in = speed_ff; sens_in = sens_ff;
      if (csr_write && csr_index == CSR_SPEED) speed_in = csr_data;
      if (csr_write && csr_index == CSR_SENS) sens_in = csr_data;
      pos_in = pos_ff; dir_in = dir_ff;
      yaw_in = yaw_ff; pitch_in = pitch_ff;
      lcx_in = lcx_ff; lcy_in = lcy_ff; first_in = first_ff; op_in = op_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; neg_in = neg_ff; step_in = step_ff;
      sy_in = sy_ff; cyw_in = cyw_ff; sp_in = sp_ff; cp_in = cp_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         op_in = req_op;
         if (req_op == OP_CURSOR) begin
            lcx_in = req_cursor_x; lcy_in = req_cursor_y; first_in = 1'b0;
            yaw_in = yaw_ff + tdx[31:0];
            if (pch > 43'(PitchLimit)) pitch_in = PitchLimit[31:0];
            else if (pch < -43'(PitchLimit)) pitch_in = -PitchLimit[31:0];
            else pitch_in = pch[31:0];
         end
      end
      if (cmd.cor_start) begin
         cx_in = CordicStart; cy_in = '0;
         cz_in = CordicW'($signed(angf));
         neg_in = (ang[31:30] == 2'b01 || ang[31:30] == 2'b10);
         step_in = '0;
      end
      if (cmd.cor_step) begin
         if (!cz_ff[CordicW-1]) begin
            cx_in = cx_ff - sy2; cy_in = cy_ff + sx; cz_in = cz_ff - atan_lut(step_ff);
         end else begin
            cx_in = cx_ff + sy2; cy_in = cy_ff - sx; cz_in = cz_ff + atan_lut(step_ff);
         end
         step_in = step_ff + 1'b1;
      end
      if (cmd.cor_done) begin
         if (cmd.cor_sel) begin sp_in = csn; cp_in = ccs; end
         else begin sy_in = csn; cyw_in = ccs; end
      end
      if (cmd.dir_mul) begin
         dir_in[0] = clamp_unit(CordicW'((36'(mp0) + 36'sd8192) >>> 14));
         dir_in[1] = sp_ff;
         dir_in[2] = clamp_unit(CordicW'((36'(mp2) + 36'sd8192) >>> 14));
      end
      if (cmd.move_mul)
         for (int k = 0; k < 3; k++) prod_in[k] = 41'(sp) * 41'(vec[k]);
      if (cmd.move_add)
         for (int k = 0; k < 3; k++)
            pos_in[k] = sat32(34'(pos_ff[k]) + 34'((prod_ff[k] + 41'sd8192) >>> 14));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0; sens_ff <= SensReset;
         pos_ff[0] <= '0; pos_ff[1] <= '0; pos_ff[2] <= PosZReset;
         dir_ff[0] <= '0; dir_ff[1] <= '0; dir_ff[2] <= -OneQ14;
         yaw_ff <= YawReset; pitch_ff <= '0;
         lcx_ff <= '0; lcy_ff <= '0; first_ff <= 1'b1;
         step_ff <= '0;
      end else begin
         speed_ff <= speed_in; sens_ff <= sens_in;
         pos_ff <= pos_in; dir_ff <= dir_in;
         yaw_ff <= yaw_in; pitch_ff <= pitch_in;
         lcx_ff <= lcx_in; lcy_ff <= lcy_in; first_ff <= first_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; neg_ff <= neg_in;
      sy_ff <= sy_in; cyw_ff <= cyw_in; sp_ff <= sp_in; cp_ff <= cp_in;
      prod_ff <= prod_in;
   end

   assign status.last_step = (step_ff == StepIdxW'(CordicSteps - 1));
   assign status.op = op_ff;
   assign pos_x = pos_ff[0];
   assign pos_y = pos_ff[1];
   assign pos_z = pos_ff[2];
   assign dir_x = dir_ff[0];
   assign dir_y = dir_ff[1];
   assign dir_z = dir_ff[2];
endmodule

// ===== hdl/fcpu_ctrl.sv =====
// Controller: sequences turn, CORDIC passes and move steps for one transaction
module fcpu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  fcpu_pkg::status_type status,
   output fcpu_pkg::cmd_type    cmd
);
   import fcpu_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_YSTRT = 10'b0000000010,
      ST_YRUN  = 10'b0000000100,
      ST_PSTRT = 10'b0000001000,
      ST_PRUN  = 10'b0000010000,
      ST_DIR   = 10'b0000100000,
      ST_MUL   = 10'b0001000000,
      ST_ADD   = 10'b0010000000,
      ST_RESP  = 10'b0100000000,
      ST_PSEED = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic pitch_ff, pitch_in;

   always_comb begin
      state_in = state_ff;
      pitch_in = pitch_ff;
      cmd = '0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RESP);
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_YSTRT;
         end
         ST_YSTRT: begin
            if (status.op == OP_CURSOR || status.op == OP_LEFT || status.op == OP_RIGHT) begin
               cmd.cor_start = 1'b1;
               pitch_in = 1'b0;
               state_in = ST_YRUN;
            end else if (status.op == OP_NONE) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_YRUN: begin
            cmd.cor_sel = pitch_ff;
            cmd.cor_step = 1'b1;
            if (status.last_step) state_in = pitch_ff ? ST_DIR : ST_PSTRT;
         end
         ST_PSTRT: begin
            cmd.cor_done = 1'b1;
            if (status.op == OP_CURSOR) begin
               state_in = ST_PSEED;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_PSEED: begin
            cmd.cor_sel = 1'b1;
            cmd.cor_start = 1'b1;
            pitch_in = 1'b1;
            state_in = ST_YRUN;
         end
         ST_DIR: begin
            cmd.cor_sel = 1'b1;
            cmd.cor_done = 1'b1;
            state_in = ST_PRUN;
         end
         ST_PRUN: begin
            cmd.dir_mul = 1'b1;
            state_in = ST_RESP;
         end
         ST_MUL: begin
            cmd.move_mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.move_add = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pitch_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pitch_ff <= pitch_in;
      end
   end
endmodule

// ===== hdl/fly_camera_pose_update.sv =====
// Top level of the fly camera pose update block
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_op, req_cursor_x, req_cursor_y
//  rsp     | out       | rsp_valid/rsp_stall | rsp_pos_*, rsp_dir_*
//  csr     | in        | csr_write           | csr_index, csr_data
// One transaction at a time; steps from acceptance to the result handshake, by op:
// cursor: turn, yaw seed, yaw CORDIC, latch, pitch seed, pitch CORDIC, latch, direction,
// result; left/right: yaw seed, yaw CORDIC, latch, multiply, add, result;
// up/down/forward/backward: multiply, add, result; unused op: result; then idle.
// Rate is set by the single shared CORDIC stepping one iteration a cycle.
// Synchronous reset restores the initial pose, angles, CSRs and control state; CORDIC work registers are not reset.
// A stalled result holds and req_stall stays high until it is taken.
module fly_camera_pose_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [15:0] req_cursor_x,
   input  logic signed [15:0] req_cursor_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [15:0] rsp_dir_x,
   output logic signed [15:0] rsp_dir_y,
   output logic signed [15:0] rsp_dir_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_data
);
   import fcpu_pkg::*;

   cmd_type    cmd;
   status_type status;

   fcpu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   fcpu_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_op, .req_cursor_x, .req_cursor_y,
      .csr_write, .csr_index, .csr_data,
      .pos_x(rsp_pos_x), .pos_y(rsp_pos_y), .pos_z(rsp_pos_z),
      .dir_x(rsp_dir_x), .dir_y(rsp_dir_y), .dir_z(rsp_dir_z)
   );
endmodule

// ===== hdl/fcpu_checker.sv =====
// Port-level assertions for the fly camera pose update block, with bind
module fcpu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [31:0] rsp_pos_x,
   input logic signed [15:0] rsp_dir_y
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x))
      else $error("result dropped under stall");
   a_no_rsp_at_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid) else $error("result without work");
   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dir_y <= 16'sd16384 && rsp_dir_y >= -16'sd16384)
      else $error("direction out of range");
endmodule

bind fly_camera_pose_update fcpu_checker u_fcpu_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_pos_x, .rsp_dir_y
);
